@@ sv/pfc_pkg.sv @@
// shared types and constants for the path front-coding encoder
// no dependencies; imported by every module of the block
`default_nettype none

package pfc_pkg;

  localparam int BYTE_W             = 8;
  localparam int PREFIX_DEPTH       = 255;
  localparam int ADDR_W             = $clog2(PREFIX_DEPTH);
  localparam int MAX_SHARED_DEFAULT = 255;

  typedef logic [BYTE_W-1:0] data_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // position value at which the byte counter saturates
  localparam data_t POS_MAX = {BYTE_W{1'b1}};

  // request held in the compare stage
  typedef struct packed {
    data_t data;
    logic  last;
    logic  empty;
    data_t pos;
    logic  cmp_ok;   // position inside both the previous path and the shared limit
  } stage_t;

  // access to the prefix memory
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    data_t wdata;
  } mem_req_t;

  typedef struct packed {
    data_t data;
    logic  is_count;
    logic  eor;
  } result_t;

endpackage

`default_nettype wire

@@ sv/pfc_prefix_ram.sv @@
// prefix memory: bytes of the previous path, one port whose write and read share one address
// read data registered, read-first on a same-address access; uses pfc_pkg
`default_nettype none

module pfc_prefix_ram (
  input  wire logic              clk,
  input  wire pfc_pkg::mem_req_t req,
  output      pfc_pkg::data_t    rdata
);
  import pfc_pkg::*;

  data_t mem [PREFIX_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/pfc_front.sv @@
// input side: position and previous length tracking, memory access, compare stage register
// uses pfc_pkg; drives pfc_prefix_ram
`default_nettype none

module pfc_front #(
  parameter int unsigned MAX_SHARED = pfc_pkg::MAX_SHARED_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire pfc_pkg::data_t    path_byte,
  input  wire logic              last_byte,
  input  wire logic              empty_path,
  input  wire logic              adv,
  output      logic              s1_valid,
  output      pfc_pkg::stage_t   s1,
  output      pfc_pkg::mem_req_t mreq
);
  import pfc_pkg::*;

  localparam logic [BYTE_W:0] SHARED_LIM = (BYTE_W+1)'(MAX_SHARED);
  localparam logic [BYTE_W:0] DEPTH_LIM  = (BYTE_W+1)'(PREFIX_DEPTH);

  data_t pos;
  data_t prev_len;
  data_t pos_inc;
  logic  accept;
  logic  in_range;

  assign in_ready = !s1_valid || adv;
  assign accept   = in_valid && in_ready;
  assign pos_inc  = (pos == POS_MAX) ? pos : pos + data_t'(1);
  assign in_range = {1'b0, pos} < DEPTH_LIM;

  // the write lands in the same cycle as the read, so the read still sees the old path
  always_comb begin
    mreq.we    = accept && !empty_path && in_range;
    mreq.re    = accept && in_range;
    mreq.addr  = pos[ADDR_W-1:0];
    mreq.wdata = path_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      prev_len <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (empty_path) begin
          prev_len <= pos;
          pos      <= '0;
        end else if (last_byte) begin
          prev_len <= pos_inc;
          pos      <= '0;
        end else begin
          pos <= pos_inc;
        end
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.data   <= path_byte;
      s1.last   <= last_byte;
      s1.empty  <= empty_path;
      s1.pos    <= pos;
      s1.cmp_ok <= ({1'b0, pos} < SHARED_LIM) && (pos < prev_len);
    end
  end

endmodule

`default_nettype wire

@@ sv/pfc_emit.sv @@
// compare stage: prefix match, shared-phase flag, result sequencing into the output register
// uses pfc_pkg; fed by pfc_front and pfc_prefix_ram
`default_nettype none

module pfc_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s1_valid,
  input  wire pfc_pkg::stage_t s1,
  input  wire pfc_pkg::data_t  rdata,
  output      logic            adv,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      pfc_pkg::data_t  out_byte,
  output      logic            is_count,
  output      logic            end_of_record
);
  import pfc_pkg::*;

  logic       shared;
  logic [1:0] idx;
  logic [1:0] n;
  logic       match;
  logic       out_free;
  logic       emit;
  logic       final_res;
  result_t    r0, r1, r2, sel;
  result_t    res_cnt, res_cnt_inc, res_byte, res_eor, res_none;
  result_t    out_res;

  assign match = s1.cmp_ok && (rdata == s1.data);

  always_comb begin
    res_cnt     = '{data: s1.pos, is_count: 1'b1, eor: 1'b0};
    res_cnt_inc = '{data: s1.pos + data_t'(1), is_count: 1'b1, eor: 1'b0};
    res_byte    = '{data: s1.data, is_count: 1'b0, eor: 1'b0};
    res_eor     = '{data: '0, is_count: 1'b0, eor: 1'b1};
    res_none    = '0;
    r0 = res_none;
    r1 = res_none;
    r2 = res_none;
    n  = 2'd0;
    if (s1.empty) begin
      if (shared) begin
        r0 = res_cnt;
        r1 = res_eor;
        n  = 2'd2;
      end else begin
        r0 = res_eor;
        n  = 2'd1;
      end
    end else if (shared && match) begin
      // still inside the shared prefix: only the end of the path speaks
      if (s1.last) begin
        r0 = res_cnt_inc;
        r1 = res_eor;
        n  = 2'd2;
      end
    end else if (shared) begin
      r0 = res_cnt;
      r1 = res_byte;
      r2 = res_eor;
      n  = s1.last ? 2'd3 : 2'd2;
    end else begin
      r0 = res_byte;
      r1 = res_eor;
      n  = s1.last ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    case (idx)
      2'd0:    sel = r0;
      2'd1:    sel = r1;
      2'd2:    sel = r2;
      default: sel = r0;
    endcase
  end

  assign out_free  = !out_valid || out_ready;
  assign emit      = s1_valid && (n != 2'd0) && out_free;
  assign final_res = (idx == n - 2'd1);
  assign adv       = s1_valid && ((n == 2'd0) || (emit && final_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      shared    <= 1'b1;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        idx <= '0;
        if (s1.empty || s1.last) begin
          shared <= 1'b1;
        end else if (shared && !match) begin
          shared <= 1'b0;
        end
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= sel;
    end
  end

  assign out_byte      = out_res.data;
  assign is_count      = out_res.is_count;
  assign end_of_record = out_res.eor;

endmodule

`default_nettype wire

@@ sv/path_front_coding_encoder.sv @@
// Path front-coding encoder. Each request carries one path byte, or an empty-path
// marker that closes the current path. Bytes that repeat the previous path (first
// 255 bytes kept in an on-chip prefix RAM) are swallowed; at the first mismatch,
// the end of the previous path or MAX_SHARED matched bytes, a count byte
// (is_count) is sent, then the byte; later bytes pass through, and every path
// closes with a zero byte flagged end_of_record. With the output never stalled,
// requests that each yield at most one result are taken back to back, one per
// cycle; a request that yields several results holds the compare stage, and so
// the input, until its last result is sent, since the single output register
// sends one result per cycle; output stalls prolong the hold. The first result
// of a request passes the registered RAM read and compare stage register, then
// is loaded into the output register once that register is free. The RAM needs
// no clearing after reset.
// Depends on pfc_pkg, pfc_front, pfc_prefix_ram, pfc_emit.
`default_nettype none

module path_front_coding_encoder #(
  parameter int unsigned MAX_SHARED = pfc_pkg::MAX_SHARED_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire pfc_pkg::data_t path_byte,
  input  wire logic           last_byte,
  input  wire logic           empty_path,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      pfc_pkg::data_t out_byte,
  output      logic           is_count,
  output      logic           end_of_record
);
  import pfc_pkg::*;

  logic     s1_valid;
  logic     adv;
  stage_t   s1;
  mem_req_t mreq;
  data_t    rdata;

  pfc_front #(
    .MAX_SHARED (MAX_SHARED)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .path_byte  (path_byte),
    .last_byte  (last_byte),
    .empty_path (empty_path),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .mreq       (mreq)
  );

  pfc_prefix_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  pfc_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .rdata         (rdata),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_count      (is_count),
    .end_of_record (end_of_record)
  );

  // closing byte is always a plain zero
  a_eor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_record |-> (out_byte == '0) && !is_count)
    else $error("end_of_record result carries data or count flag");

  // a request that is still sending results stays put in the compare stage
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("compare stage changed before its results were sent");

  // prefix memory writes stay inside the stored depth
  a_mem_range: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> ({1'b0, mreq.addr} < (ADDR_W+1)'(PREFIX_DEPTH)) && mreq.re)
    else $error("prefix memory access out of range");

endmodule

`default_nettype wire
